FILE: hw/rtl/fdcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_pkg
// Shared types and constants of the frame difference change detector.
// ----------------------------------------------------------------------------
package fdcd_pkg;

    // linear position y*width+x fits 16 bits: 127*511+255 < 2^16
    localparam int LIN_W      = 16;
    localparam int SUM_W      = 33;
    localparam int SQ_SUM_W   = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 33;

    localparam logic [8:0]       FRAME_WIDTH_RESET = 9'd160;
    localparam logic [SUM_W-1:0] THRESHOLD_RESET   = 33'd20000000;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t color;
        logic frame_start;
        logic frame_end;
    } pix_t;

endpackage

FILE: hw/rtl/fdcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_if
// Valid/ready channels for incoming pixels and outgoing frame results.
// ----------------------------------------------------------------------------
interface pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_x;
    logic [6:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
    logic       frame_end;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, frame_start, frame_end,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, frame_start, frame_end,
        output ready
    );
endinterface

interface result_if;
    logic        valid;
    logic        ready;
    logic [32:0] difference_total;
    logic        frame_changed;

    modport source (
        output valid, difference_total, frame_changed,
        input  ready
    );
    modport sink (
        input  valid, difference_total, frame_changed,
        output ready
    );
endinterface

FILE: hw/rtl/fdcd_addr_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_addr_gen
// Three-stage address pipeline: y*width+x, then reduction modulo the store
// depth by reciprocal multiply with one final correction step.
// ----------------------------------------------------------------------------
module fdcd_addr_gen #(
    parameter int STORE_DEPTH = 32768,
    parameter int ADDR_W      = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic [7:0]              pixel_x,
    input  logic [6:0]              pixel_y,
    input  fdcd_pkg::pix_t          in_pix,
    input  logic [8:0]              frame_width,
    output logic                    out_valid,
    output logic [ADDR_W-1:0]       out_addr,
    output fdcd_pkg::pix_t          out_pix
);

    localparam int LIN_W = fdcd_pkg::LIN_W;
    localparam int PROD_W = 2 * LIN_W + 1;
    // floor(2^LIN_W / depth); the estimate is low by at most one
    localparam int unsigned RECIP_INT = (32'd1 << LIN_W) / STORE_DEPTH;
    localparam logic [LIN_W:0] RECIP = RECIP_INT[LIN_W:0];
    localparam logic [31:0] DEPTH_32 = 32'(STORE_DEPTH);

    logic                 valid1_reg, valid2_reg, valid3_reg;
    logic [LIN_W-1:0]     lin1_reg, lin2_reg, q2_reg, rem3_reg;
    fdcd_pkg::pix_t       pix1_reg, pix2_reg, pix3_reg;

    logic [LIN_W-1:0]     lin1_next;
    logic [PROD_W-1:0]    prod2_next;
    logic [31:0]          qd_full;
    logic [LIN_W-1:0]     rem3_next;
    logic [31:0]          rem_ext;
    logic [31:0]          addr_full;

    assign lin1_next  = LIN_W'(pixel_y) * LIN_W'(frame_width) + LIN_W'(pixel_x);
    assign prod2_next = PROD_W'(lin1_reg) * PROD_W'(RECIP);
    assign qd_full    = 32'(q2_reg) * DEPTH_32;
    assign rem3_next  = lin2_reg - qd_full[LIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lin1_reg <= lin1_next;
            pix1_reg <= in_pix;
            lin2_reg <= lin1_reg;
            q2_reg   <= prod2_next[LIN_W +: LIN_W];
            pix2_reg <= pix1_reg;
            rem3_reg <= rem3_next;
            pix3_reg <= pix2_reg;
        end
    end

    // remainder is below twice the depth here
    assign rem_ext   = 32'(rem3_reg);
    assign addr_full = (rem_ext >= DEPTH_32) ? (rem_ext - DEPTH_32) : rem_ext;

    assign out_valid = valid3_reg;
    assign out_addr  = addr_full[ADDR_W-1:0];
    assign out_pix   = pix3_reg;

endmodule

FILE: hw/rtl/fdcd_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_frame_store
// Previous-frame pixel memory, one read and one write port, registered read,
// write-to-read forwarding and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module fdcd_frame_store #(
    parameter int STORE_DEPTH = 32768,
    parameter int ADDR_W      = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output fdcd_pkg::rgb_t          rd_data,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  fdcd_pkg::rgb_t          wr_data,
    output logic                    busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    fdcd_pkg::rgb_t     mem [STORE_DEPTH];
    fdcd_pkg::rgb_t     rd_q_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;

    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    fdcd_pkg::rgb_t     fwd_data_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    fdcd_pkg::rgb_t     mem_wdata;

    assign mem_we    = clearing_reg | wr_en;
    assign mem_waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clearing_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // latest item write; covers a write that lands on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en && !clearing_reg)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !clearing_reg)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                       : rd_q_reg;
    assign busy    = clearing_reg;

endmodule

FILE: hw/rtl/fdcd_diff_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_diff_accum
// Compares each pixel with the stored one, writes the new pixel back,
// squares and sums the channel differences and keeps the saturating total.
// ----------------------------------------------------------------------------
module fdcd_diff_accum #(
    parameter int ADDR_W = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ADDR_W-1:0]             in_addr,
    input  fdcd_pkg::pix_t                in_pix,
    input  fdcd_pkg::rgb_t                rd_data,
    input  logic [fdcd_pkg::SUM_W-1:0]    threshold,
    output logic                          advance,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr,
    output fdcd_pkg::rgb_t                wr_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fdcd_pkg::SUM_W-1:0]    out_total,
    output logic                          out_changed
);

    localparam int SUM_W    = fdcd_pkg::SUM_W;
    localparam int SQ_SUM_W = fdcd_pkg::SQ_SUM_W;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // compare stage, fed by the address pipeline and the store read
    logic               valid4_reg;
    logic [ADDR_W-1:0]  addr4_reg;
    fdcd_pkg::pix_t     pix4_reg;

    // square stage
    logic               valid5_reg;
    logic [7:0]         dr5_reg, dg5_reg, db5_reg;
    logic               start5_reg, end5_reg;

    // accumulate stage
    logic                   valid6_reg;
    logic [SQ_SUM_W-1:0]    add6_reg;
    logic                   start6_reg, end6_reg;

    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic                   out_valid_reg;
    logic [SUM_W-1:0]       out_total_reg;
    logic                   out_changed_reg;

    logic [SQ_SUM_W-1:0]    add6_next;
    logic [SUM_W-1:0]       base;
    logic [SUM_W:0]         total_wide;
    logic                   load_out;

    assign advance  = !(valid6_reg && end6_reg && out_valid_reg && !out_ready);
    assign load_out = advance && valid6_reg && end6_reg;

    assign wr_en   = advance && valid4_reg;
    assign wr_addr = addr4_reg;
    assign wr_data = pix4_reg.color;

    assign add6_next = SQ_SUM_W'(16'(dr5_reg) * 16'(dr5_reg))
                     + SQ_SUM_W'(16'(dg5_reg) * 16'(dg5_reg))
                     + SQ_SUM_W'(16'(db5_reg) * 16'(db5_reg));

    assign base       = start6_reg ? '0 : sum_reg;
    assign total_wide = {1'b0, base} + (SUM_W + 1)'(add6_reg);
    assign sum_next   = total_wide[SUM_W] ? '1 : total_wide[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg    <= 1'b0;
            valid5_reg    <= 1'b0;
            valid6_reg    <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid4_reg <= in_valid;
                valid5_reg <= valid4_reg;
                valid6_reg <= valid5_reg;
                if (valid6_reg)
                begin
                    sum_reg <= sum_next;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            addr4_reg  <= in_addr;
            pix4_reg   <= in_pix;
            dr5_reg    <= abs_diff(rd_data.red,   pix4_reg.color.red);
            dg5_reg    <= abs_diff(rd_data.green, pix4_reg.color.green);
            db5_reg    <= abs_diff(rd_data.blue,  pix4_reg.color.blue);
            start5_reg <= pix4_reg.frame_start;
            end5_reg   <= pix4_reg.frame_end;
            add6_reg   <= add6_next;
            start6_reg <= start5_reg;
            end6_reg   <= end5_reg;
        end
        if (load_out)
        begin
            out_total_reg   <= sum_next;
            out_changed_reg <= (sum_next > threshold);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_total   = out_total_reg;
    assign out_changed = out_changed_reg;

endmodule

FILE: hw/rtl/frame_difference_change_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_change_detector_top
// Sum of squared RGB differences against the stored previous frame, with a
// changed-frame flag on the last pixel of each frame.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and keeps taking pixels while a frame result
// waits at the output; only a frame-end pixel that meets a still-occupied
// result register holds the pipeline. A pixel passes three address stages
// (y*width+x loaded at the accepting edge, then a reciprocal-multiply
// reduction modulo the store depth), a frame store read, then difference,
// square and accumulate stages; a frame-end pixel then loads the result
// register. The store has one read and one write port; a pixel that reads
// the entry written by the pixel just ahead of it gets that value forwarded.
// After reset the store is swept to zero one entry per clock over all
// WIDTH_MAX*HEIGHT_MAX entries (32768 with the default sizes), and no pixel
// is taken until the sweep ends; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module frame_difference_change_detector_top #(
    parameter int WIDTH_MAX  = 256,
    parameter int HEIGHT_MAX = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pixel_if.sink                               pixel_in,
    result_if.source                            result_out,
    input  logic                                cfg_write,
    input  logic [fdcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int STORE_DEPTH = WIDTH_MAX * HEIGHT_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [8:0]                     frame_width_reg;
    logic [fdcd_pkg::SUM_W-1:0]     change_threshold_reg;

    logic                   advance;
    logic                   store_busy;
    logic                   in_fire;
    fdcd_pkg::pix_t         in_pix;

    logic                   ag_valid;
    logic [ADDR_W-1:0]      ag_addr;
    fdcd_pkg::pix_t         ag_pix;

    fdcd_pkg::rgb_t         rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    fdcd_pkg::rgb_t         wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= fdcd_pkg::FRAME_WIDTH_RESET;
            change_threshold_reg <= fdcd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fdcd_pkg::REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[8:0];
                fdcd_pkg::REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data;
            endcase
        end
    end

    assign pixel_in.ready = advance && !store_busy;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    assign in_pix.color.red   = pixel_in.red;
    assign in_pix.color.green = pixel_in.green;
    assign in_pix.color.blue  = pixel_in.blue;
    assign in_pix.frame_start = pixel_in.frame_start;
    assign in_pix.frame_end   = pixel_in.frame_end;

    fdcd_addr_gen #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_addr_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_fire),
        .pixel_x     (pixel_in.pixel_x),
        .pixel_y     (pixel_in.pixel_y),
        .in_pix      (in_pix),
        .frame_width (frame_width_reg),
        .out_valid   (ag_valid),
        .out_addr    (ag_addr),
        .out_pix     (ag_pix)
    );

    fdcd_frame_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_frame_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance),
        .rd_addr (ag_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (store_busy)
    );

    fdcd_diff_accum #(
        .ADDR_W (ADDR_W)
    ) u_diff_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (ag_valid),
        .in_addr     (ag_addr),
        .in_pix      (ag_pix),
        .rd_data     (rd_data),
        .threshold   (change_threshold_reg),
        .advance     (advance),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (result_out.valid),
        .out_ready   (result_out.ready),
        .out_total   (result_out.difference_total),
        .out_changed (result_out.frame_changed)
    );

endmodule

FILE: tb/fdcd_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_frame_tracker
// Watches the pixel, result and register-write traffic of the frame
// difference change detector. Keeps its own copy of the previous frame and
// the running sum of squared differences, predicts the total and the changed
// flag of every frame-end pixel, and compares them with the block's results
// in order.
// ----------------------------------------------------------------------------
module fdcd_frame_tracker
    import fdcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pixel_if                      pix,
    result_if                     res,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    outstanding,
    output int                    frames_checked,
    output int                    frames_flagged
);

    localparam int               STORE_DEPTH = 256 * 128;
    localparam logic [SUM_W-1:0] SUM_MAX     = '1;

    typedef struct packed {
        logic [SUM_W-1:0] difference_total;
        logic             frame_changed;
    } frame_verdict_t;

    frame_verdict_t   pending_verdicts[$];
    rgb_t             prev_frame [STORE_DEPTH];
    logic [8:0]       row_width;
    logic [SUM_W-1:0] change_limit;
    logic [SUM_W-1:0] ssd_sum;

    function automatic logic [17:0] channel_sq(input logic [7:0] a, input logic [7:0] b);
        logic [17:0] d;
        d = (a > b) ? 18'(a - b) : 18'(b - a);
        return d * d;
    endfunction

    function automatic logic [17:0] pixel_ssd(input rgb_t was, input rgb_t now);
        return channel_sq(was.red, now.red) + channel_sq(was.green, now.green)
            + channel_sq(was.blue, now.blue);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned      addr;
        logic [SUM_W:0]   grown;
        logic [SUM_W:0]   step_add;
        rgb_t             color;
        frame_verdict_t   want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                prev_frame[i] = '0;
            pending_verdicts.delete();
            row_width      = FRAME_WIDTH_RESET;
            change_limit   = THRESHOLD_RESET;
            ssd_sum        = '0;
            failures       = 0;
            outstanding    = 0;
            frames_checked = 0;
            frames_flagged = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    row_width = cfg_data[8:0];
                else if (cfg_index == REG_CHANGE_THRESHOLD)
                    change_limit = cfg_data[SUM_W-1:0];
            end

            if (res.valid && res.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected frame result: difference_total %0d frame_changed %0d",
                        res.difference_total, res.frame_changed);
                    failures++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (res.difference_total !== want.difference_total)
                    begin
                        $error("difference_total: expected %0d, actual %0d",
                            want.difference_total, res.difference_total);
                        failures++;
                    end
                    if (res.frame_changed !== want.frame_changed)
                    begin
                        $error("frame_changed: expected %0d, actual %0d",
                            want.frame_changed, res.frame_changed);
                        failures++;
                    end
                    frames_checked++;
                    if (want.frame_changed)
                        frames_flagged++;
                end
            end

            if (pix.valid && pix.ready)
            begin
                // store address wraps modulo the store depth
                addr = (32'(pix.pixel_y) * 32'(row_width) + 32'(pix.pixel_x)) % STORE_DEPTH;
                color = {pix.red, pix.green, pix.blue};
                if (pix.frame_start)
                    ssd_sum = '0;
                step_add = (SUM_W+1)'(pixel_ssd(prev_frame[addr], color));
                grown = {1'b0, ssd_sum} + step_add;
                // saturate instead of wrapping
                ssd_sum = grown[SUM_W] ? SUM_MAX : grown[SUM_W-1:0];
                prev_frame[addr] = color;
                if (pix.frame_end)
                    pending_verdicts.push_back({ssd_sum, ssd_sum > change_limit});
            end

            outstanding = pending_verdicts.size();
        end
    end

endmodule

FILE: tb/tb_frame_difference_change_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_difference_change_detector_top
// Pixel stimulus and verdict for the frame difference change detector: a
// directed pass over field extremes, threshold edges, width corner values and
// store wrap, then random frames of small regions under several width and
// threshold settings, with random gaps on the pixel side and random stalls
// on the result side.
// ----------------------------------------------------------------------------
module tb_frame_difference_change_detector_top;
    import fdcd_pkg::*;

    localparam int               PHASES            = 8;
    localparam int               PHASE_ITEMS       = 206;
    localparam int               SETTLE_CYCLES     = 16;
    localparam int               CYCLE_LIMIT       = 700000;
    localparam logic [SUM_W-1:0] SUM_MAX           = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int failures;
    int outstanding;
    int frames_checked;
    int frames_flagged;
    int pixels_sent;
    int cycle_count = 0;
    bit calm_sink   = 1'b0;

    pixel_if  pix_ch ();
    result_if res_ch ();

    frame_difference_change_detector_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pix_ch),
        .result_out (res_ch),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    fdcd_frame_tracker tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix            (pix_ch),
        .res            (res_ch),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .failures       (failures),
        .outstanding    (outstanding),
        .frames_checked (frames_checked),
        .frames_flagged (frames_flagged)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // result side back-pressure, with calm stretches of no stalls
    initial
    begin
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                calm_sink = !calm_sink;
            if (hold > 0)
            begin
                hold--;
                res_ch.ready = 1'b0;
            end
            else
            begin
                res_ch.ready = 1'b1;
                if (!calm_sink && $urandom_range(0, 5) == 0)
                    hold = idle_len();
            end
        end
    end

    task automatic send_pixel(input logic [7:0] x, input logic [6:0] y, input rgb_t color,
                              input logic fs, input logic fe);
        @(negedge clk);
        pix_ch.valid       = 1'b1;
        pix_ch.pixel_x     = x;
        pix_ch.pixel_y     = y;
        pix_ch.red         = color.red;
        pix_ch.green       = color.green;
        pix_ch.blue        = color.blue;
        pix_ch.frame_start = fs;
        pix_ch.frame_end   = fe;
        do @(posedge clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    task automatic pause_pixels(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            pix_ch.valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // non-end pixels may still be in flight after the last result
    task automatic drain_results();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // raster scan of a small region; a few frames get random start/end marks
    task automatic random_frame();
        int   wr;
        int   hr;
        int   x0;
        int   y0;
        bit   broken;
        bit   coarse;
        bit   steady;
        logic fs;
        logic fe;
        rgb_t color;
        wr     = $urandom_range(1, 12);
        hr     = $urandom_range(1, 6);
        x0     = $urandom_range(0, 256 - wr);
        y0     = $urandom_range(0, 128 - hr);
        broken = ($urandom_range(0, 9) == 0);
        coarse = $urandom_range(0, 1);
        steady = ($urandom_range(0, 4) == 0);
        for (int r = 0; r < hr; r++)
        begin
            for (int c = 0; c < wr; c++)
            begin
                if (broken)
                begin
                    fs = ($urandom_range(0, 7) == 0);
                    fe = ($urandom_range(0, 7) == 0);
                end
                else
                begin
                    fs = (r == 0 && c == 0);
                    fe = (r == hr - 1 && c == wr - 1);
                end
                if (coarse)
                    color = rgb_t'($urandom);
                else
                    color = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                             8'($urandom_range(0, 15))};
                send_pixel(8'(x0 + c), 7'(y0 + r), color, fs, fe);
                if (!steady)
                    pause_pixels(idle_len());
            end
        end
    endtask

    initial
    begin
        int                    phase_start;
        logic [8:0]            width_pick;
        logic [CFG_DATA_W-1:0] limit_pick;

        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_FRAME_WIDTH;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_x     = '0;
        pix_ch.pixel_y     = '0;
        pix_ch.red         = '0;
        pix_ch.green       = '0;
        pix_ch.blue        = '0;
        pix_ch.frame_start = 1'b0;
        pix_ch.frame_end   = 1'b0;
        pixels_sent        = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset settings; first frame without a start mark, sum kept after an end
        send_pixel(8'd0, 7'd0, 24'hFFFFFF, 1'b0, 1'b1);
        send_pixel(8'd255, 7'd127, 24'h000000, 1'b0, 1'b0);
        send_pixel(8'd255, 7'd127, 24'hFFFFFF, 1'b0, 1'b1);

        // total equal to threshold, then one above it
        drain_results();
        program_reg(REG_CHANGE_THRESHOLD, 33'd195075);
        send_pixel(8'd1, 7'd0, 24'hFFFFFF, 1'b1, 1'b1);
        send_pixel(8'd2, 7'd0, 24'hFFFFFF, 1'b1, 1'b0);
        send_pixel(8'd3, 7'd0, 24'h000001, 1'b0, 1'b1);

        // zero threshold with zero width: address is the column alone
        drain_results();
        program_reg(REG_CHANGE_THRESHOLD, '0);
        program_reg(REG_FRAME_WIDTH, 33'd0);
        send_pixel(8'd2, 7'd0, 24'hFFFFFF, 1'b1, 1'b1);
        send_pixel(8'd9, 7'd77, 24'h800000, 1'b1, 1'b1);

        // widest row: addresses past the store wrap around
        drain_results();
        program_reg(REG_FRAME_WIDTH, 33'd511);
        program_reg(REG_CHANGE_THRESHOLD, SUM_MAX);
        send_pixel(8'd255, 7'd127, 24'h00FF00, 1'b1, 1'b0);
        send_pixel(8'd128, 7'd64, 24'h0000FF, 1'b0, 1'b0);
        send_pixel(8'd255, 7'd127, 24'hFF00FF, 1'b0, 1'b1);

        // width one: two positions on one entry back to back
        drain_results();
        program_reg(REG_FRAME_WIDTH, 33'd1);
        send_pixel(8'd255, 7'd127, 24'h123456, 1'b1, 1'b0);
        send_pixel(8'd0, 7'd1, 24'hAAAAAA, 1'b0, 1'b0);
        send_pixel(8'd1, 7'd0, 24'h555555, 1'b0, 1'b1);

        // full-size row reaches the last entry
        drain_results();
        program_reg(REG_FRAME_WIDTH, 33'd256);
        send_pixel(8'd255, 7'd127, 24'hFFFFFF, 1'b1, 1'b0);
        send_pixel(8'd0, 7'd0, 24'h000000, 1'b0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       width_pick = 9'd0;
                1:       width_pick = 9'd1;
                2:       width_pick = 9'd511;
                3:       width_pick = 9'd256;
                4:       width_pick = FRAME_WIDTH_RESET;
                default: width_pick = 9'($urandom_range(2, 510));
            endcase
            if (p == 5)
                limit_pick = '0;
            else if (p == 6)
                limit_pick = SUM_MAX;
            else
                limit_pick = 33'($urandom_range(0, 1500000));
            program_reg(REG_FRAME_WIDTH, 33'(width_pick));
            program_reg(REG_CHANGE_THRESHOLD, limit_pick);
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_ITEMS)
            begin
                random_frame();
                if ($urandom_range(0, 14) == 0)
                    drain_results();
            end
        end

        drain_results();
        $display("%0d pixels sent, %0d frame results checked, %0d of them flagged changed",
            pixels_sent, frames_checked, frames_flagged);
        $display("widths 0/1/160/256/511 and random, thresholds 0/max/random, store wrap");
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
